@@ rtl/ordered_list_insert_delete_search_assert.svh @@
// Assertion macros used by the ordered list top module.
`ifndef ORDERED_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_SEARCH_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define OLIST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define OLIST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/olist_pkg.sv @@
package olist_pkg;

    // List capacity.
    localparam int DEPTH = 16;

    // Field widths fixed by the interface.
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int IDX_IN_W = 4;

    // Count width: enough for DEPTH, never narrower than the position field.
    localparam int CNT_W = ($clog2(DEPTH + 1) > POS_W) ? $clog2(DEPTH + 1) : POS_W;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_DELETE = 3'd2,
        REQ_SEARCH = 3'd3,
        REQ_READ   = 3'd4
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_DELETE,
        CELL_FIND
    } cell_cmd_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        cell_cmd_t         cmd;
        logic [DATA_W-1:0] operand;
    } cell_ctrl_t;

endpackage

@@ rtl/olist_cell.sv @@
module olist_cell
    import olist_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic              valid,
    input  logic              tail,
    input  logic [DATA_W-1:0] left,
    input  logic [DATA_W-1:0] right,
    input  logic              hit_in,
    output logic              hit_out,
    output logic              first,
    output logic [DATA_W-1:0] entry
);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic              eq;
    logic              ge;
    logic              match_self;

    // Compare own entry against the broadcast operand.
    assign eq = valid && (entry_reg == ctrl.operand);
    assign ge = valid && ($signed(entry_reg) >= $signed(ctrl.operand));

    always_comb
    begin
        unique case (ctrl.cmd)
            CELL_INSERT: match_self = ge;
            CELL_DELETE,
            CELL_FIND:   match_self = eq;
            default:     match_self = 1'b0;
        endcase
    end

    // Pass the hit downstream; flag the first matching cell.
    assign hit_out = hit_in | match_self;
    assign first   = match_self & ~hit_in;

    // Load operand, shift from a neighbor, or hold.
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.cmd)
            CELL_APPEND:
            begin
                if (tail)
                begin
                    entry_next = ctrl.operand;
                end
            end
            CELL_INSERT:
            begin
                if (hit_in)
                begin
                    entry_next = left;
                end
                else if (match_self || tail)
                begin
                    entry_next = ctrl.operand;
                end
            end
            CELL_DELETE:
            begin
                if (hit_out)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ rtl/ordered_list_insert_delete_search.sv @@
// Sorted insertion list of up to DEPTH signed 32-bit entries kept in a row of
// shift cells. Each transaction carries one request (append, ordered insert,
// delete first match, search, read by index) and returns one result with status,
// 1-based position, read value and the entry count afterwards. A request is
// first registered; then every cell compares its entry with the operand, the
// hit flag ripples down the chain and all cells shift or load together. The next
// request is taken as soon as the current one leaves the compare step, so a new
// request is not accepted before the last one is through; a result waiting on the
// output does not block the next accept, but it stalls that request's compare.
module ordered_list_insert_delete_search
    import olist_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // value[31:0], read_index[35:32], zero pad
    input  logic [2:0]  s_tuser,  // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // status[1:0], position[6:2], read_value[38:7],
                                  // entry_count[43:39], zero pad
);

`include "ordered_list_insert_delete_search_assert.svh"

    logic                busy_reg;
    logic                busy_next;
    logic [2:0]          kind_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [IDX_IN_W-1:0] index_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    status_t             status_reg;
    status_t             status_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [DATA_W-1:0]   rdv_reg;
    logic [DATA_W-1:0]   rdv_next;

    logic                accept;
    logic                fire;
    logic                full;
    cell_ctrl_t          ctrl;
    logic [DEPTH-1:0]    valid;
    logic [DEPTH-1:0]    tail;
    logic [DEPTH-1:0]    first;
    logic [DEPTH:0]      hit;
    logic [DATA_W-1:0]   entry [DEPTH];
    logic [CNT_W-1:0]    first_pos;
    logic [CNT_W-1:0]    index_ext;
    logic [DATA_W-1:0]   index_entry;
    logic [CNT_W-1:0]    pos_full;

    // Handshake: one request in flight, output register parts the sides.
    assign s_tready = ~busy_reg;
    assign accept   = s_tvalid & s_tready;
    assign fire     = busy_reg & (~out_valid_reg | m_tready);
    assign full     = (count_reg == CNT_W'(DEPTH));

    // Capture the request payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= s_tuser;
            value_reg <= s_tdata[31:0];
            index_reg <= s_tdata[35:32];
        end
    end

    // Per-cell occupancy and tail slot from the count.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid[i] = (CNT_W'(i) < count_reg);
            tail[i]  = (CNT_W'(i) == count_reg);
        end
    end

    // Build the command for the cells.
    always_comb
    begin
        ctrl.operand = value_reg;
        ctrl.cmd     = CELL_HOLD;
        if (fire)
        begin
            unique case (kind_reg)
                REQ_APPEND: ctrl.cmd = full ? CELL_HOLD : CELL_APPEND;
                REQ_INSERT: ctrl.cmd = full ? CELL_HOLD : CELL_INSERT;
                REQ_DELETE: ctrl.cmd = CELL_DELETE;
                REQ_SEARCH: ctrl.cmd = CELL_FIND;
                default:    ctrl.cmd = CELL_HOLD;
            endcase
        end
    end

    // Cell chain.
    assign hit[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (g == 0)
        begin : g_head
            assign left_w = value_reg;
        end
        else
        begin : g_body
            assign left_w = entry[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_end
            assign right_w = entry[g];
        end
        else
        begin : g_mid
            assign right_w = entry[g+1];
        end

        olist_cell u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .valid   (valid[g]),
            .tail    (tail[g]),
            .left    (left_w),
            .right   (right_w),
            .hit_in  (hit[g]),
            .hit_out (hit[g+1]),
            .first   (first[g]),
            .entry   (entry[g])
        );
    end

    // Encode the first hit and select the entry for a read.
    assign index_ext = CNT_W'(index_reg);

    always_comb
    begin
        first_pos   = '0;
        index_entry = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first[i])
            begin
                first_pos = first_pos | CNT_W'(i + 1);
            end
            if (CNT_W'(i) == index_ext)
            begin
                index_entry = index_entry | entry[i];
            end
        end
    end

    // Result and count update.
    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        pos_full    = '0;
        rdv_next    = '0;
        unique case (kind_reg)
            REQ_APPEND:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    pos_full   = count_reg + CNT_W'(1);
                end
            end
            REQ_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    pos_full   = hit[DEPTH] ? first_pos : (count_reg + CNT_W'(1));
                end
            end
            REQ_DELETE:
            begin
                if (hit[DEPTH])
                begin
                    count_next = count_reg - CNT_W'(1);
                    pos_full   = first_pos;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            REQ_SEARCH:
            begin
                if (hit[DEPTH])
                begin
                    pos_full = first_pos;
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            REQ_READ:
            begin
                if (index_ext < count_reg)
                begin
                    rdv_next = index_entry;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
        pos_next = pos_full[POS_W-1:0];
    end

    // Control next state.
    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
        end
        if (accept)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Hold the result until the transaction completes downstream.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            rdv_reg    <= rdv_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, count_reg[POS_W-1:0], rdv_reg, pos_reg, status_reg};

    `OLIST_ASSERT_ALWAYS(a_count_range, !rst_n || (count_reg <= CNT_W'(DEPTH)), "count exceeds depth")
    `OLIST_ASSERT(a_accept_busy, accept |=> busy_reg, "accepted request not held")
    `OLIST_ASSERT(a_fire_out, fire |=> out_valid_reg, "result not presented after execute")
    `OLIST_ASSERT(a_count_hold, !fire |=> $stable(count_reg), "count changed without request")
    `OLIST_ASSERT(a_no_overlap, busy_reg |-> !s_tready, "second request taken while busy")

endmodule
